### rtl/core/dksis_pkg.sv
// Package for the dual-key stable insertion sorter: defaults, record layout, shared types.
`default_nettype none

package dksis_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned TAG_BITS       = 16;

  // Sorted-list record: {key, head_tag, kind, tag}
  localparam int unsigned REC_TAG_LSB  = 0;
  localparam int unsigned REC_KIND_BIT = TAG_BITS;
  localparam int unsigned REC_HEAD_LSB = TAG_BITS + 1;
  localparam int unsigned REC_KEY_LSB  = 2 * TAG_BITS + 1;

  // Result load strobe from sequencer to output register
  typedef struct packed {
    logic load;
    logic last;
    logic ovf;
  } dksis_emit_t;

endpackage

`default_nettype wire

### rtl/core/dksis_if.sv
// Item and result channel interfaces of the dual-key stable insertion sorter.
`default_nettype none

interface dksis_item_if #(
  parameter int unsigned COORD_BITS = dksis_pkg::COORD_BITS_DEF
);
  import dksis_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [TAG_BITS-1:0]          item_tag;
  logic                         item_kind;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic                         last_item;

  modport source (output valid, item_tag, item_kind, x_coord, y_coord, last_item,
                  input ready);
  modport sink   (input valid, item_tag, item_kind, x_coord, y_coord, last_item,
                  output ready);
endinterface

interface dksis_res_if;
  import dksis_pkg::*;

  logic                valid;
  logic                ready;
  logic [TAG_BITS-1:0] x_rank_tag;
  logic                x_rank_kind;
  logic [TAG_BITS-1:0] x_group_tag;
  logic [TAG_BITS-1:0] y_rank_tag;
  logic                y_rank_kind;
  logic [TAG_BITS-1:0] y_group_tag;
  logic                overflowed;
  logic                last_out;

  modport source (output valid, x_rank_tag, x_rank_kind, x_group_tag, y_rank_tag,
                  y_rank_kind, y_group_tag, overflowed, last_out,
                  input ready);
  modport sink   (input valid, x_rank_tag, x_rank_kind, x_group_tag, y_rank_tag,
                  y_rank_kind, y_group_tag, overflowed, last_out,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/dksis_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none

module dksis_ram #(
  parameter int unsigned DEPTH = dksis_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/dksis_ctrl.sv
// Sequencer with the shared key comparator: insertion scans and rank readout.
`default_nettype none

module dksis_ctrl #(
  parameter int unsigned CAPACITY   = dksis_pkg::CAPACITY_DEF,
  parameter int unsigned COORD_BITS = dksis_pkg::COORD_BITS_DEF,
  localparam int unsigned AW   = $clog2(CAPACITY),
  localparam int unsigned RW   = COORD_BITS + 2 * dksis_pkg::TAG_BITS + 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  dksis_item_if.sink             item_i,
  output logic                   rd_en_o,
  output logic [AW-1:0]          rd_addr_o,
  input  wire logic [RW-1:0]     x_rdata_i,
  input  wire logic [RW-1:0]     y_rdata_i,
  output logic                   x_we_o,
  output logic                   y_we_o,
  output logic [AW-1:0]          wr_addr_o,
  output logic [RW-1:0]          wr_data_o,
  output dksis_pkg::dksis_emit_t emit_o,
  input  wire logic              out_free_i
);
  import dksis_pkg::*;

  localparam int unsigned CNTW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FIRST = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_LOAD  = 5'b01000,
    ST_EMIT  = 5'b10000
  } dksis_state_e;

  dksis_state_e state_q, state_d;
  logic [CNTW-1:0] fill_q, fill_d;
  logic            ovf_q, ovf_d;
  logic            pass_q, pass_d;
  logic [AW-1:0]   pos_q, pos_d;

  logic [TAG_BITS-1:0]          tag_q;
  logic                         kind_q;
  logic signed [COORD_BITS-1:0] x_q, y_q;
  logic                         last_q;

  logic                         accept;
  logic                         full;
  logic                         we;
  logic [RW-1:0]                rd_rec;
  logic signed [COORD_BITS-1:0] rd_key, key;
  logic                         key_gt, key_eq;
  logic [TAG_BITS-1:0]          head_tag;
  logic [RW-1:0]                new_rec;

  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && (state_q == ST_IDLE);
  assign full         = (fill_q == CNTW'(CAPACITY));

  // shared comparator
  assign rd_rec   = pass_q ? y_rdata_i : x_rdata_i;
  assign rd_key   = signed'(rd_rec[REC_KEY_LSB +: COORD_BITS]);
  assign key      = pass_q ? y_q : x_q;
  assign key_gt   = rd_key > key;
  assign key_eq   = rd_key == key;
  assign head_tag = ((state_q == ST_SCAN) && key_eq) ? rd_rec[REC_HEAD_LSB +: TAG_BITS]
                                                     : tag_q;
  assign new_rec  = {key, head_tag, kind_q, tag_q};

  assign x_we_o = we && !pass_q;
  assign y_we_o = we && pass_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q  <= item_i.item_tag;
      kind_q <= item_i.item_kind;
      x_q    <= item_i.x_coord;
      y_q    <= item_i.y_coord;
      last_q <= item_i.last_item;
    end
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    ovf_d     = ovf_q;
    pass_d    = pass_q;
    pos_d     = pos_q;
    rd_en_o   = 1'b0;
    rd_addr_o = pos_q - AW'(1);
    we        = 1'b0;
    wr_addr_o = pos_q;
    wr_data_o = new_rec;
    emit_o    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
            if (item_i.last_item) begin
              rd_en_o   = 1'b1;
              rd_addr_o = '0;
              pos_d     = '0;
              state_d   = ST_EMIT;
            end
          end else begin
            pass_d  = 1'b0;
            pos_d   = fill_q[AW-1:0];
            state_d = ST_FIRST;
          end
        end
      end
      ST_FIRST, ST_SCAN: begin
        if (state_q == ST_SCAN && key_gt) begin
          we        = 1'b1;
          wr_data_o = rd_rec;
          pos_d     = pos_q - AW'(1);
          if (pos_q == AW'(1)) begin
            state_d = ST_FIRST;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = pos_q - AW'(2);
            state_d   = ST_SCAN;
          end
        end else if (state_q == ST_FIRST && pos_q != '0) begin
          rd_en_o = 1'b1;
          state_d = ST_SCAN;
        end else begin
          we = 1'b1;
          if (!pass_q) begin
            pass_d  = 1'b1;
            pos_d   = fill_q[AW-1:0];
            state_d = ST_FIRST;
          end else begin
            fill_d = fill_q + CNTW'(1);
            if (last_q) begin
              pos_d   = '0;
              state_d = ST_LOAD;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_LOAD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = '0;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free_i) begin
          emit_o.load = 1'b1;
          emit_o.ovf  = ovf_q;
          emit_o.last = (CNTW'(pos_q) + CNTW'(1)) == fill_q;
          if (emit_o.last) begin
            fill_d  = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = pos_q + AW'(1);
            pos_d     = pos_q + AW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      pass_q  <= 1'b0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      pass_q  <= pass_d;
      pos_q   <= pos_d;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNTW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_we_o || y_we_o) |-> (state_q == ST_FIRST || state_q == ST_SCAN))
    else $error("list write outside an insertion pass");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.load && emit_o.last) |=> (state_q == ST_IDLE && fill_q == '0 && !ovf_q))
    else $error("set not cleared after final rank");

  a_drop_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && !item_i.last_item) |=> (state_q == ST_IDLE && ovf_q))
    else $error("dropped request not flagged");
`endif

endmodule

`default_nettype wire

### rtl/core/dual_key_stable_insertion_sort.sv
// Top level of the dual-key stable insertion sorter: list RAMs, sequencer, output register.
//
//   channel  modport  request
//   item_i   sink     one element (tag, kind, x, y, last flag)
//   res_o    source   one rank of both sorted orders after a last element
//
// An insert shifts each larger entry up by one place; the single compare unit walks the x list,
// then the y list, one entry per cycle.
// After a last element comes readout: one result per cycle from both RAM read ports while the output register is free.
// Reset clears the fill count and overflow flag; the list RAMs are not cleared.
// A stalled result holds in the output register; item_i stays low-ready while busy.
`default_nettype none

module dual_key_stable_insertion_sort #(
  parameter int unsigned CAPACITY   = dksis_pkg::CAPACITY_DEF,
  parameter int unsigned COORD_BITS = dksis_pkg::COORD_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dksis_item_if.sink item_i,
  dksis_res_if.source res_o
);
  import dksis_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned RW = COORD_BITS + 2 * TAG_BITS + 1;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [RW-1:0] x_rdata, y_rdata;
  logic          x_we, y_we;
  logic [AW-1:0] wr_addr;
  logic [RW-1:0] wr_data;
  dksis_emit_t   emit;
  logic          out_free;
  logic          out_vld_q, out_vld_d;

  dksis_ctrl #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .x_rdata_i  (x_rdata),
    .y_rdata_i  (y_rdata),
    .x_we_o     (x_we),
    .y_we_o     (y_we),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .emit_o     (emit),
    .out_free_i (out_free)
  );

  dksis_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (RW)
  ) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (x_rdata)
  );

  dksis_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (RW)
  ) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (y_rdata)
  );

  assign out_free  = !out_vld_q || res_o.ready;
  assign out_vld_d = emit.load ? 1'b1 : (res_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      res_o.x_rank_tag  <= x_rdata[REC_TAG_LSB +: TAG_BITS];
      res_o.x_rank_kind <= x_rdata[REC_KIND_BIT];
      res_o.x_group_tag <= x_rdata[REC_HEAD_LSB +: TAG_BITS];
      res_o.y_rank_tag  <= y_rdata[REC_TAG_LSB +: TAG_BITS];
      res_o.y_rank_kind <= y_rdata[REC_KIND_BIT];
      res_o.y_group_tag <= y_rdata[REC_HEAD_LSB +: TAG_BITS];
      res_o.overflowed  <= emit.ovf;
      res_o.last_out    <= emit.last;
    end
  end

  assign res_o.valid = out_vld_q;

endmodule

`default_nettype wire

### tb/sv/dksis_order_check.sv
// Order checker: watches the item and result channels, predicts the x/y rank results and compares.
`timescale 1ns / 100ps

module dksis_order_check #(
  parameter int unsigned CAPACITY   = dksis_pkg::CAPACITY_DEF,
  parameter int unsigned COORD_BITS = dksis_pkg::COORD_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dksis_item_if       item_mon,
  dksis_res_if        res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import dksis_pkg::*;

  localparam int X_AXIS = 0;
  localparam int Y_AXIS = 1;
  localparam int unsigned PRINT_CAP = 40;

  typedef struct packed {
    logic [TAG_BITS-1:0] x_tag;
    logic                x_kind;
    logic [TAG_BITS-1:0] x_head;
    logic [TAG_BITS-1:0] y_tag;
    logic                y_kind;
    logic [TAG_BITS-1:0] y_head;
    logic                ovf;
    logic                last;
  } rank_row_t;

  logic [TAG_BITS-1:0]          elem_tag   [CAPACITY];
  logic                         elem_kind  [CAPACITY];
  logic signed [COORD_BITS-1:0] elem_key   [2][CAPACITY];
  int unsigned                  rank_list  [2][CAPACITY];
  int unsigned                  group_head [2][CAPACITY];
  int unsigned                  stored = 0;
  logic                         dropped = 1'b0;
  rank_row_t                    expected_ranks [$];
  int unsigned                  mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [TAG_BITS-1:0] got,
                               input logic [TAG_BITS-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s mismatch: got %h, expected %h", name, got, want));
  endtask

  // stable placement: after every stored key <= new key
  task automatic rank_insert(input int axis, input int unsigned n);
    int unsigned pos;
    logic signed [COORD_BITS-1:0] k;
    k = elem_key[axis][n];
    pos = n;
    while (pos > 0 && elem_key[axis][rank_list[axis][pos-1]] > k) pos--;
    for (int unsigned i = n; i > pos; i--) rank_list[axis][i] = rank_list[axis][i-1];
    rank_list[axis][pos] = n;
    if (pos > 0 && elem_key[axis][rank_list[axis][pos-1]] == k)
      group_head[axis][n] = group_head[axis][rank_list[axis][pos-1]];
    else
      group_head[axis][n] = n;
  endtask

  task automatic take_element();
    rank_row_t   row;
    int unsigned xe;
    int unsigned ye;
    if (stored < CAPACITY) begin
      elem_tag[stored]        = item_mon.item_tag;
      elem_kind[stored]       = item_mon.item_kind;
      elem_key[X_AXIS][stored] = item_mon.x_coord;
      elem_key[Y_AXIS][stored] = item_mon.y_coord;
      rank_insert(X_AXIS, stored);
      rank_insert(Y_AXIS, stored);
      stored++;
    end else begin
      dropped = 1'b1;
    end
    if (item_mon.last_item) begin
      for (int unsigned r = 0; r < stored; r++) begin
        xe = rank_list[X_AXIS][r];
        ye = rank_list[Y_AXIS][r];
        row.x_tag  = elem_tag[xe];
        row.x_kind = elem_kind[xe];
        row.x_head = elem_tag[group_head[X_AXIS][xe]];
        row.y_tag  = elem_tag[ye];
        row.y_kind = elem_kind[ye];
        row.y_head = elem_tag[group_head[Y_AXIS][ye]];
        row.ovf    = dropped;
        row.last   = (r + 1 == stored);
        expected_ranks.push_back(row);
      end
      stored  = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic check_rank();
    rank_row_t want;
    if (expected_ranks.size() == 0) begin
      report_mismatch($sformatf("unexpected result, x_rank_tag %h y_rank_tag %h",
                                res_mon.x_rank_tag, res_mon.y_rank_tag));
    end else begin
      want = expected_ranks.pop_front();
      compare_field("x_rank_tag", res_mon.x_rank_tag, want.x_tag);
      compare_field("x_rank_kind", TAG_BITS'(res_mon.x_rank_kind), TAG_BITS'(want.x_kind));
      compare_field("x_group_tag", res_mon.x_group_tag, want.x_head);
      compare_field("y_rank_tag", res_mon.y_rank_tag, want.y_tag);
      compare_field("y_rank_kind", TAG_BITS'(res_mon.y_rank_kind), TAG_BITS'(want.y_kind));
      compare_field("y_group_tag", res_mon.y_group_tag, want.y_head);
      compare_field("overflowed", TAG_BITS'(res_mon.overflowed), TAG_BITS'(want.ovf));
      compare_field("last_out", TAG_BITS'(res_mon.last_out), TAG_BITS'(want.last));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stored  = 0;
      dropped = 1'b0;
    end else begin
      if (item_mon.valid && item_mon.ready) take_element();
      if (res_mon.valid && res_mon.ready) check_rank();
    end
    pending_o <= expected_ranks.size();
  end

endmodule

### tb/sv/testbench.sv
// Testbench top: element stimulus, result backpressure, reset, clock and verdict.
`timescale 1ns / 100ps

module testbench;
  import dksis_pkg::*;

  localparam int unsigned CAPACITY     = CAPACITY_DEF;
  localparam int unsigned COORD_BITS   = COORD_BITS_DEF;
  localparam int unsigned ITEM_TARGET  = 400;
  localparam int unsigned CALM_AFTER   = 340;
  localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 20;

  typedef enum int {KEYS_WIDE, KEYS_TIED, KEYS_EDGE} key_spread_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned random_sent = 0;
  bit          calm = 1'b0;

  dksis_item_if #(.COORD_BITS(COORD_BITS)) item_bus ();
  dksis_res_if res_bus ();

  dual_key_stable_insertion_sort #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_bus),
    .res_o  (res_bus)
  );

  dksis_order_check #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS)
  ) sort_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_mon     (item_bus),
    .res_mon      (res_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_element(input logic [TAG_BITS-1:0] tag, input logic kind,
                              input logic signed [COORD_BITS-1:0] x,
                              input logic signed [COORD_BITS-1:0] y, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    item_bus.valid     <= 1'b1;
    item_bus.item_tag  <= tag;
    item_bus.item_kind <= kind;
    item_bus.x_coord   <= x;
    item_bus.y_coord   <= y;
    item_bus.last_item <= last;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
  endtask

  function automatic logic signed [COORD_BITS-1:0] pick_coord(input key_spread_e spread);
    int          v;
    int unsigned raw;
    raw = $urandom;
    case (spread)
      KEYS_TIED: begin
        v = int'($urandom_range(0, 4)) - 2;
        return v[COORD_BITS-1:0];
      end
      KEYS_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
          1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return raw[COORD_BITS-1:0];
    endcase
  endfunction

  task automatic send_random_set(input int unsigned count);
    key_spread_e x_spread;
    key_spread_e y_spread;
    x_spread = key_spread_e'($urandom_range(0, 2));
    y_spread = key_spread_e'($urandom_range(0, 2));
    for (int unsigned i = 0; i < count; i++) begin
      send_element(TAG_BITS'($urandom), 1'($urandom), pick_coord(x_spread),
                   pick_coord(y_spread), i + 1 == count);
      random_sent++;
      if (random_sent >= CALM_AFTER) calm = 1'b1;
    end
  endtask

  // result side backpressure
  initial begin
    res_bus.ready <= 1'b0;
    repeat (11) @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned r;
    rst_ni             <= 1'b0;
    item_bus.valid     <= 1'b0;
    item_bus.item_tag  <= '0;
    item_bus.item_kind <= 1'b0;
    item_bus.x_coord   <= '0;
    item_bus.y_coord   <= '0;
    item_bus.last_item <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-element sets at the field extremes
    send_element(16'hFFFF, 1'b1, 16'sh8000, 16'sh7FFF, 1'b1);
    send_element(16'h0000, 1'b0, 16'sh7FFF, 16'sh8000, 1'b1);
    // one x group, y falling
    for (int i = 0; i < 6; i++)
      send_element(TAG_BITS'(16'h0100 + i), i[0], 16'sd5, COORD_BITS'(16'sd10 - i), i == 5);
    // x falling with extremes, y in tied pairs
    for (int i = 0; i < 8; i++)
      send_element(TAG_BITS'(16'h0200 + i), ~i[0],
                   (i == 0) ? 16'sh7FFF : (i == 7) ? 16'sh8000 : COORD_BITS'(16'sd7 - i),
                   COORD_BITS'((i >> 1) - 1), i == 7);
    // interleaved ties in both orders
    send_element(16'h0300, 1'b0, 16'sd0, 16'sd3, 1'b0);
    send_element(16'h0301, 1'b1, -16'sd1, 16'sd3, 1'b0);
    send_element(16'h0302, 1'b0, 16'sd0, -16'sd3, 1'b0);
    send_element(16'h0303, 1'b1, -16'sd1, 16'sd3, 1'b0);
    send_element(16'h0304, 1'b1, 16'sd1, -16'sd3, 1'b1);

    // exactly full, then full with dropped inserts including the last one
    send_random_set(CAPACITY);
    send_random_set(CAPACITY + 3);
    while (random_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 15);
      if (r == 0) send_random_set(CAPACITY + $urandom_range(0, 3));
      else if (r <= 3) send_random_set($urandom_range(13, 40));
      else send_random_set($urandom_range(1, 12));
    end
    item_bus.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
